>>> design/ffba_pkg.sv
// Shared types and constants for the FIFO free-list block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned NumBlocks = 1024;
  localparam int unsigned IdxW      = $clog2(NumBlocks);

  typedef logic [IdxW-1:0] idx_t;

  localparam idx_t LastBlk = idx_t'(NumBlocks - 1);

  // Request codes.
  localparam logic ReqAlloc = 1'b0;
  localparam logic ReqFree  = 1'b1;

  // Status codes.
  localparam logic StatusDone    = 1'b0;
  localparam logic StatusRefused = 1'b1;

  // One link entry: a valid flag and the index of the next free block.
  typedef struct packed {
    logic ok;
    idx_t idx;
  } link_t;

  // Write request into the link store.
  typedef struct packed {
    logic  en;
    idx_t  addr;
    link_t data;
  } link_wr_t;

  // Result of one request, before the output register.
  typedef struct packed {
    idx_t granted;
    logic status;
  } result_t;

endpackage

>>> design/ffba_link_store.sv
// Next-link store: one write port and one registered read port with write forwarding.
`timescale 1ns / 1ps

module ffba_link_store (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ffba_pkg::link_wr_t wr_i,
  input  ffba_pkg::idx_t   raddr_i,
  output ffba_pkg::link_t  rdata_o
);
  import ffba_pkg::*;

  link_t mem [NumBlocks];
  link_t rdata_q;
  link_t fwd_data_q;
  logic  fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rdata_q    <= mem[raddr_i];
    fwd_data_q <= wr_i.data;
  end

  // A write to the address being read in the same cycle must be seen by the read.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= wr_i.en && (wr_i.addr == raddr_i);
    end
  end

  assign rdata_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

>>> design/ffba_list_ctrl.sv
// Free-list control: head and tail pointers, the reset sweep and the per-request decision.
`timescale 1ns / 1ps

module ffba_list_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               req_type_i,
  input  ffba_pkg::idx_t     freed_block_i,
  input  ffba_pkg::link_t    head_link_i,
  output ffba_pkg::link_wr_t wr_o,
  output ffba_pkg::idx_t     raddr_o,
  output logic               ready_o,
  output ffba_pkg::result_t  res_o
);
  import ffba_pkg::*;

  idx_t head_q, head_d;
  idx_t tail_q, tail_d;
  idx_t init_cnt_q;
  logic init_busy_q;
  logic head_ok;
  logic blk_in_pool;

  // The tail's stored link is not kept null, so it is never trusted: a head equal to the tail is refused.
  assign head_ok     = head_link_i.ok && (head_q != tail_q);
  assign blk_in_pool = 32'(freed_block_i) < NumBlocks;

  always_comb begin
    head_d        = head_q;
    tail_d        = tail_q;
    wr_o.en       = 1'b0;
    wr_o.addr     = head_q;
    wr_o.data.ok  = 1'b0;
    wr_o.data.idx = '0;
    res_o.granted = '0;
    res_o.status  = StatusDone;

    if (init_busy_q) begin
      wr_o.en       = 1'b1;
      wr_o.addr     = init_cnt_q;
      wr_o.data.ok  = (init_cnt_q != LastBlk);
      wr_o.data.idx = init_cnt_q + idx_t'(1);
    end else if (accept_i) begin
      case (req_type_i)
        ReqAlloc: begin
          if (head_ok) begin
            res_o.granted = head_q;
            head_d        = head_link_i.idx;
            wr_o.en       = 1'b1;
            wr_o.addr     = head_q;
          end else begin
            res_o.status = StatusRefused;
          end
        end
        ReqFree: begin
          // Freeing the current tail leaves the list as it is.
          if (blk_in_pool && (freed_block_i != tail_q)) begin
            wr_o.en       = 1'b1;
            wr_o.addr     = tail_q;
            wr_o.data.ok  = 1'b1;
            wr_o.data.idx = freed_block_i;
            tail_d        = freed_block_i;
          end
        end
        default: begin
          res_o.status = StatusDone;
        end
      endcase
    end
  end

  // The store always reads the link of the block that will be head next cycle.
  assign raddr_o = head_d;
  assign ready_o = !init_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= LastBlk;
      init_cnt_q  <= '0;
      init_busy_q <= 1'b1;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      if (init_busy_q) begin
        init_cnt_q <= init_cnt_q + idx_t'(1);
        if (init_cnt_q == LastBlk) begin
          init_busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

>>> design/fifo_free_list_block_allocator.sv
// FIFO free-list block allocator: top level with the result register.
//
//   port group     dir   handshake               payload
//   request        in    in_valid_i/in_ready_o   req_type_i, freed_block_i
//   result         out   out_valid_o/out_ready_i granted_block_o, status_o
//
// One request word is accepted per cycle while in_ready_o is high; its result word is
// registered and ready in the next cycle. The head's link is read every cycle from the
// registered store port, with forwarding of the write made in the same cycle, so
// back-to-back allocates do not stall. After reset a sweep chains all 1024 link entries,
// one per cycle; in_ready_o stays low until the sweep ends. A stalled result holds the
// request side only while the result register is full and out_ready_i is low.
`timescale 1ns / 1ps

module fifo_free_list_block_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           req_type_i,
  input  ffba_pkg::idx_t freed_block_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ffba_pkg::idx_t granted_block_o,
  output logic           status_o
);
  import ffba_pkg::*;

  link_wr_t wr;
  link_t    head_link;
  idx_t     raddr;
  result_t  res;
  logic     ctrl_ready;
  logic     accept;
  logic     out_valid_q;
  idx_t     granted_q;
  logic     status_q;

  assign in_ready_o = ctrl_ready && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  ffba_list_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .freed_block_i (freed_block_i),
    .head_link_i   (head_link),
    .wr_o          (wr),
    .raddr_o       (raddr),
    .ready_o       (ctrl_ready),
    .res_o         (res)
  );

  ffba_link_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .raddr_i (raddr),
    .rdata_o (head_link)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      granted_q <= res.granted;
      status_q  <= res.status;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign granted_block_o = granted_q;
  assign status_o        = status_q;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the FIFO free-list block allocator.
`timescale 1ns / 1ps

module tb;
  import ffba_pkg::*;

  typedef struct {
    logic req;
    idx_t blk;
  } req_word_t;

  typedef enum int unsigned {RxFull, RxHalf, RxSparse, RxEveryThird} rx_mode_e;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic req_type_i;
  idx_t freed_block_i;
  logic out_valid_o;
  logic out_ready_i;
  idx_t granted_block_o;
  logic status_o;

  fifo_free_list_block_allocator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .freed_block_i  (freed_block_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .granted_block_o(granted_block_o),
    .status_o       (status_o)
  );

  // Predicted allocator state.
  link_t pool_link [NumBlocks];
  idx_t  pool_head;
  idx_t  pool_tail;
  result_t grant_expect_q[$];
  result_t want;

  // Stimulus planning keeps the free list as a plain queue of block indexes.
  req_word_t req_plan_q[$];
  idx_t      free_list_q[$];
  bit        on_list [NumBlocks];

  int unsigned n_planned, n_offered, n_accepted, n_fail;
  int unsigned n_granted, n_refused, n_returned;
  int unsigned burst_left, gap_left;
  int unsigned hold_left, holds_done, mode_left, rx_phase;
  rx_mode_e    rx_mode;

  function automatic result_t pool_step(logic req, idx_t blk);
    result_t r;
    r.granted = '0;
    r.status  = StatusDone;
    if (req == ReqAlloc) begin
      // The last block on the list has a null link and stays in reserve.
      if (pool_link[pool_head].ok && int'(pool_link[pool_head].idx) < NumBlocks) begin
        r.granted = pool_head;
        pool_head = pool_link[pool_head].idx;
        pool_link[r.granted] = '0;
        n_granted++;
      end else begin
        r.status = StatusRefused;
        n_refused++;
      end
    end else begin
      if (int'(blk) < NumBlocks) begin
        pool_link[pool_tail] = '{ok: 1'b1, idx: blk};
        pool_link[blk] = '0;
        pool_tail = blk;
      end
      n_returned++;
    end
    return r;
  endfunction

  // Queues one word and tracks which blocks are on the free list afterwards.
  task automatic plan_item(logic req, idx_t blk);
    req_plan_q.push_back('{req, blk});
    if (req == ReqAlloc) begin
      if (free_list_q.size() > 1) begin
        on_list[free_list_q[0]] = 1'b0;
        void'(free_list_q.pop_front());
      end
    end else if (on_list[blk]) begin
      // Returning a listed block ends the list at that block.
      while (free_list_q[$] != blk) begin
        on_list[free_list_q[$]] = 1'b0;
        void'(free_list_q.pop_back());
      end
    end else begin
      free_list_q.push_back(blk);
      on_list[blk] = 1'b1;
    end
  endtask

  task automatic plan_random(int unsigned count);
    int unsigned done, seg, alloc_pct, pick;
    idx_t b;
    done = 0;
    while (done < count) begin
      seg = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       alloc_pct = 20;
        1:       alloc_pct = 50;
        default: alloc_pct = 85;
      endcase
      repeat (seg) begin
        b = idx_t'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          case ($urandom_range(0, 3))
            0:       b = free_list_q[0];
            1:       b = free_list_q[$];
            2:       b = free_list_q[$urandom_range(0, free_list_q.size() - 1)];
            default: ;
          endcase
          plan_item(ReqFree, b);
        end else if ($urandom_range(0, 99) < alloc_pct || free_list_q.size() == NumBlocks) begin
          plan_item(ReqAlloc, b);
        end else begin
          do b = idx_t'($urandom); while (on_list[b]);
          plan_item(ReqFree, b);
        end
        done++;
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("fifo_free_list_block_allocator regression: fail");
    $finish;
  end

  // Driver: bursts of words separated by random gaps.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && n_accepted != n_offered) begin
        // Word still waiting for in_ready_o.
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left--;
      end else if (req_plan_q.size() > 0) begin
        in_valid_i    <= 1'b1;
        req_type_i    <= req_plan_q[0].req;
        freed_block_i <= req_plan_q[0].blk;
        void'(req_plan_q.pop_front());
        n_offered++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: changing stall patterns, plus two long hold-offs that back up the input.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_phase++;
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (holds_done < 2 && n_accepted >= (holds_done == 0 ? 40 : 500)) begin
        out_ready_i <= 1'b0;
        hold_left = 300;
        holds_done++;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 100);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RxFull:   out_ready_i <= 1'b1;
          RxHalf:   out_ready_i <= 1'($urandom_range(0, 1));
          RxSparse: out_ready_i <= ($urandom_range(0, 3) == 0);
          default:  out_ready_i <= (rx_phase % 3 == 0);
        endcase
      end
    end
  end

  // Monitor: predicts on each accepted request and checks each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        grant_expect_q.push_back(pool_step(req_type_i, freed_block_i));
        n_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (grant_expect_q.size() == 0) begin
          $error("result word with no request pending: granted_block %0d, status %0d",
                 granted_block_o, status_o);
          n_fail++;
        end else begin
          want = grant_expect_q.pop_front();
          if (granted_block_o !== want.granted) begin
            $error("granted_block: expected %0d, got %0d", want.granted, granted_block_o);
            n_fail++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            n_fail++;
          end
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    req_type_i    = ReqAlloc;
    freed_block_i = '0;
    out_ready_i   = 1'b0;
    rx_mode       = RxFull;

    for (int i = 0; i < NumBlocks; i++) begin
      pool_link[i] = '{ok: (i != NumBlocks - 1), idx: idx_t'(i + 1)};
      free_list_q.push_back(idx_t'(i));
      on_list[i] = 1'b1;
    end
    pool_link[NumBlocks - 1].idx = '0;
    pool_head = '0;
    pool_tail = LastBlk;

    // Directed opening: plain allocates, returning the tail, cutting the list short,
    // reaching the reserve block and collapsing the list by returning its head.
    plan_item(ReqAlloc, LastBlk);
    plan_item(ReqAlloc, '0);
    plan_item(ReqFree, LastBlk);
    plan_item(ReqFree, '0);
    plan_item(ReqAlloc, idx_t'(512));
    plan_item(ReqFree, idx_t'(1));
    plan_item(ReqFree, idx_t'(5));
    plan_item(ReqAlloc, '0);
    plan_item(ReqAlloc, '0);
    plan_item(ReqAlloc, '0);
    plan_item(ReqAlloc, LastBlk);
    plan_item(ReqFree, LastBlk);
    plan_item(ReqAlloc, '0);
    plan_item(ReqAlloc, '0);
    plan_item(ReqFree, '0);
    plan_item(ReqFree, idx_t'(512));
    plan_item(ReqFree, idx_t'(10'h155));
    plan_item(ReqFree, idx_t'(10'h2aa));
    plan_item(ReqFree, LastBlk);
    plan_item(ReqAlloc, '0);
    plan_item(ReqFree, idx_t'(10'h2aa));
    plan_item(ReqAlloc, '0);
    plan_random(800);
    n_planned = req_plan_q.size();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (n_accepted < n_planned) @(posedge clk_i);
    while (grant_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d requests: %0d blocks granted, %0d allocates refused at the reserve,",
             n_accepted, n_granted, n_refused);
    $display("%0d blocks returned, %0d mismatches", n_returned, n_fail);
    if (n_fail == 0) begin
      $display("fifo_free_list_block_allocator regression: pass");
    end else begin
      $display("fifo_free_list_block_allocator regression: fail");
    end
    $finish;
  end

endmodule
